// File: rtl/pcpt_pkg.sv
// Package for the perceptron training step core.
// Holds widths, reset constants, the control state type and the lane update struct.
// Used by pcpt_lane, pcpt_merge and perceptron_training_step_core.
package pcpt_pkg;

    localparam int MAX_FEATURES = 8;
    localparam int FEATURES_DEF = 8;
    localparam int FEAT_W       = 16;
    localparam int WEIGHT_W     = 32;
    localparam int RATE_W       = 16;
    localparam int PROD_W       = WEIGHT_W + FEAT_W;
    localparam int XR_W         = FEAT_W + RATE_W + 1;
    localparam int DIFF_W       = 3;
    localparam int TERM_W       = XR_W + DIFF_W - 1;
    localparam int FRAC_DROP    = 12;
    localparam int STEP_W       = TERM_W - FRAC_DROP;
    localparam int TGT_W        = 2;
    localparam int S_TDATA_W    = 136;
    localparam int M_TDATA_W    = 8;

    localparam logic signed [FEAT_W-1:0] BIAS_INPUT = 16'sd4096;
    localparam logic [RATE_W-1:0]        RATE_RESET = 16'd6554;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic                     en;
        logic signed [DIFF_W-1:0] diff;
    } upd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_UPD,
        S_HOLD
    } state_t;

endpackage

// File: rtl/pcpt_lane.sv
// One weight lane of the perceptron core: weight register, product and update term.
// Depends on pcpt_pkg.
module pcpt_lane
    import pcpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic signed [FEAT_W-1:0] x_in,
    input  logic [RATE_W-1:0]        rate,
    input  upd_t                     upd,
    output prod_t                    prod
);

    logic signed [WEIGHT_W-1:0] weight_reg;
    logic signed [WEIGHT_W-1:0] weight_next;
    prod_t                      prod_reg;
    logic signed [XR_W-1:0]     xr_reg;
    logic signed [TERM_W-1:0]   term;
    logic signed [STEP_W-1:0]   step;
    logic signed [WEIGHT_W:0]   wsum;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(weight_reg) * PROD_W'(x_in);
            xr_reg   <= XR_W'(x_in) * $signed(XR_W'({1'b0, rate}));
        end
    end

    // The update term is floored to Q.16 by dropping the low fraction bits.
    always_comb
    begin
        term = TERM_W'(upd.diff) * TERM_W'(xr_reg);
        step = term[TERM_W-1:FRAC_DROP];
        wsum = (WEIGHT_W + 1)'(weight_reg) + (WEIGHT_W + 1)'(step);
        if (wsum[WEIGHT_W] != wsum[WEIGHT_W-1])
        begin
            weight_next = wsum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                         : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
        else
        begin
            weight_next = wsum[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= '0;
        end
        else if (upd.en)
        begin
            weight_reg <= weight_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: rtl/pcpt_merge.sv
// Merging stage of the perceptron core: sums the lane products and gives the sign.
// Depends on pcpt_pkg.
module pcpt_merge
    import pcpt_pkg::*;
#(
    parameter int NW = FEATURES_DEF + 1
)
(
    input  prod_t                   prod [NW],
    output logic signed [TGT_W-1:0] sign
);

    localparam int SUM_W = PROD_W + $clog2(NW) + 1;

    logic signed [SUM_W-1:0] acc;

    always_comb
    begin
        acc = '0;
        for (int k = 0; k < NW; k++)
        begin
            acc = acc + SUM_W'(prod[k]);
        end
        if (acc == '0)
        begin
            sign = 2'sd0;
        end
        else if (acc[SUM_W-1])
        begin
            sign = -2'sd1;
        end
        else
        begin
            sign = 2'sd1;
        end
    end

endmodule

// File: rtl/perceptron_training_step_core.sv
// Top level of the perceptron training step core: control, lanes and merging stage.
// Depends on pcpt_pkg, pcpt_lane and pcpt_merge.
//
//   Channel  | Direction | Item contents
//   s_axis   | in        | tdata: feature_0..7, target_class; tuser: learn_enable; tlast: epoch_end
//   m_axis   | out       | tdata: prediction, mismatch; tuser: epoch_clean
//   cfg      | in        | learning_rate, written when cfg_we is high
//
// An item passes through the lane multipliers, then the merging adder, then the
// weight update. The next item is accepted once the result is stored.
// A result that waits on m_axis_tready holds the core in its last step.
// Reset clears all weights and the epoch flag and sets the learning rate to 6554.
module perceptron_training_step_core
    import pcpt_pkg::*;
#(
    parameter int FEATURES = FEATURES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // feature_0 .. feature_7 (16 bits each), target_class (2 bits), zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // learn_enable
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // prediction (2 bits), mismatch (1 bit), zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // epoch_clean
    output logic                 m_axis_tuser,
    input  logic                 cfg_we,
    input  logic [RATE_W-1:0]    cfg_wdata
);

    localparam int NW = FEATURES + 1;

    state_t                  state_reg;
    state_t                  state_next;
    logic [RATE_W-1:0]       rate_reg;
    logic signed [TGT_W-1:0] tgt_reg;
    logic                    learn_reg;
    logic                    end_reg;
    logic signed [TGT_W-1:0] pred_reg;
    logic                    seen_reg;
    logic                    out_valid_reg;
    logic signed [TGT_W-1:0] out_pred_reg;
    logic                    out_miss_reg;
    logic                    out_clean_reg;

    logic                    accept;
    logic                    slot_free;
    logic                    load_out;
    logic                    miss;
    logic signed [TGT_W-1:0] tgt_dec;
    logic signed [TGT_W-1:0] sign;
    upd_t                    upd;
    prod_t                   prod [NW];

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign load_out  = ((state_reg == S_UPD) || (state_reg == S_HOLD)) && slot_free;
    assign miss      = (tgt_reg != pred_reg);
    // The pattern for minus two is taken as minus one.
    assign tgt_dec   = (s_axis_tdata[MAX_FEATURES*FEAT_W +: TGT_W] == 2'b10) ? -2'sd1
                     : $signed(s_axis_tdata[MAX_FEATURES*FEAT_W +: TGT_W]);

    assign upd.en   = (state_reg == S_UPD) && learn_reg && miss;
    assign upd.diff = DIFF_W'(tgt_reg) - DIFF_W'(pred_reg);

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_lane
            logic signed [FEAT_W-1:0] x_lane;
            if (k == 0)
            begin : g_bias
                assign x_lane = BIAS_INPUT;
            end
            else
            begin : g_feat
                assign x_lane = $signed(s_axis_tdata[(k-1)*FEAT_W +: FEAT_W]);
            end
            pcpt_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .load  (accept),
                .x_in  (x_lane),
                .rate  (rate_reg),
                .upd   (upd),
                .prod  (prod[k])
            );
        end
    endgenerate

    pcpt_merge #(
        .NW (NW)
    ) u_merge (
        .prod (prod),
        .sign (sign)
    );

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = slot_free ? S_IDLE : S_HOLD;
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rate_reg      <= RATE_RESET;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                seen_reg      <= end_reg ? 1'b0 : (seen_reg || miss);
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tgt_reg   <= tgt_dec;
            learn_reg <= s_axis_tuser;
            end_reg   <= s_axis_tlast;
        end
        if (state_reg == S_SUM)
        begin
            pred_reg <= sign;
        end
        if (load_out)
        begin
            out_pred_reg  <= pred_reg;
            out_miss_reg  <= miss;
            out_clean_reg <= end_reg && !(seen_reg || miss);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-TGT_W-1){1'b0}}, out_miss_reg, out_pred_reg};
    assign m_axis_tuser  = out_clean_reg;

endmodule
